[hw/rtl/coap_message_parser_assert.svh]
// Assertion helpers for the CoAP parser; both expect clk and arst_n in scope.
`ifndef COAP_MESSAGE_PARSER_ASSERT_SVH
`define COAP_MESSAGE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define COAP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("coap parser assertion failed");
`define COAP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coap parser assertion failed");
`else
`define COAP_ASSERT(lbl, cond)
`define COAP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/coap_pkg.sv]
`timescale 1ns / 1ps
package coap_pkg;

	localparam int OPT_W = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} coap_in_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic [7:0]  byte_value;
		logic [1:0]  message_type;
		logic [3:0]  token_length;
		logic [7:0]  message_code;
		logic [15:0] message_id;
		logic [15:0] option_number;
		logic [15:0] option_length;
		logic [3:0]  option_index;
		logic        packet_end;
		logic [1:0]  packet_status;
	} coap_out_t;

	localparam logic [2:0] ROLE_HEADER   = 3'd0;
	localparam logic [2:0] ROLE_TOKEN    = 3'd1;
	localparam logic [2:0] ROLE_OPTHEAD  = 3'd2;
	localparam logic [2:0] ROLE_OPTVALUE = 3'd3;
	localparam logic [2:0] ROLE_MARKER   = 3'd4;
	localparam logic [2:0] ROLE_PAYLOAD  = 3'd5;
	localparam logic [2:0] ROLE_IGNORED  = 3'd6;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_OPT_ERR = 2'd2;

	localparam logic [OPT_W-1:0] OPTION_LIMIT_RESET = 4'd10;

	localparam logic [1:0]  COAP_VERSION = 2'd1;
	localparam logic [3:0]  TKL_MAX      = 4'd8;
	localparam logic [3:0]  NIB_EXT1     = 4'd13;
	localparam logic [3:0]  NIB_EXT2     = 4'd14;
	localparam logic [3:0]  NIB_RSVD     = 4'd15;
	localparam logic [7:0]  PAYLOAD_MARK = 8'hFF;
	localparam logic [15:0] EXT1_BIAS    = 16'd13;
	localparam logic [15:0] EXT2_BIAS    = 16'd269;

endpackage

[hw/rtl/coap_parse_core.sv]
`timescale 1ns / 1ps
module coap_parse_core #(
	parameter int MAX_DATAGRAM_BYTES = 1024,
	parameter int MAX_OPTIONS = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  coap_pkg::coap_in_t            item,
	input  logic [coap_pkg::OPT_W-1:0]    option_limit,
	output coap_pkg::coap_out_t           result
);
	import coap_pkg::*;

	localparam int CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);

	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_TOKEN   = 4'd1;
	localparam logic [3:0] PH_OPTION  = 4'd2;
	localparam logic [3:0] PH_DEXT1   = 4'd3;
	localparam logic [3:0] PH_DEXT2A  = 4'd4;
	localparam logic [3:0] PH_DEXT2B  = 4'd5;
	localparam logic [3:0] PH_LEXT1   = 4'd6;
	localparam logic [3:0] PH_LEXT2A  = 4'd7;
	localparam logic [3:0] PH_LEXT2B  = 4'd8;
	localparam logic [3:0] PH_VALUE   = 4'd9;
	localparam logic [3:0] PH_PAYLOAD = 4'd10;
	localparam logic [3:0] PH_IGNORE  = 4'd11;

	logic [3:0]       phase_q, phase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]      hdr_q, hdr_n;
	logic [3:0]       tok_q, tok_n;
	logic [15:0]      num_q, num_n;
	logic [3:0]       nib_q, nib_n;
	logic [7:0]       ext_q, ext_n;
	logic [15:0]      rem_q, rem_n;
	logic [OPT_W-1:0] seen_q, seen_n;
	logic [1:0]       err_q, err_n;
	logic [15:0]      len_q, len_n;

	logic [OPT_W-1:0] limit;
	logic [2:0]       role;
	logic             len_stage, set_len, finish;
	logic [15:0]      len_val;
	logic [1:0]       end_status;
	logic [7:0]       b;

	assign b = item.data_byte;
	assign limit = (option_limit < OPT_W'(MAX_OPTIONS)) ? option_limit : OPT_W'(MAX_OPTIONS);

	always_comb begin
		phase_n = phase_q;
		cnt_n = cnt_q;
		hdr_n = hdr_q;
		tok_n = tok_q;
		num_n = num_q;
		nib_n = nib_q;
		ext_n = ext_q;
		rem_n = rem_q;
		seen_n = seen_q;
		err_n = err_q;
		len_n = len_q;
		role = ROLE_IGNORED;
		len_stage = 1'b0;
		set_len = 1'b0;
		len_val = '0;
		finish = 1'b0;
		// past the buffer size a byte leaves the state alone
		if (cnt_q < CNT_W'(MAX_DATAGRAM_BYTES)) begin
			cnt_n = cnt_q + CNT_W'(1);
			case (phase_q)
				PH_HEADER: begin
					role = ROLE_HEADER;
					case (cnt_q[1:0])
						2'd0: hdr_n[31:24] = hdr_q[31:24] | b;
						2'd1: hdr_n[23:16] = hdr_q[23:16] | b;
						2'd2: hdr_n[15:8] = hdr_q[15:8] | b;
						default: hdr_n[7:0] = hdr_q[7:0] | b;
					endcase
					if (cnt_q == '0 && (b[7:6] != COAP_VERSION || b[3:0] > TKL_MAX)) begin
						err_n = STATUS_DROPPED;
					end
					if (cnt_q == CNT_W'(3)) begin
						tok_n = hdr_n[27:24];
						if (err_n != STATUS_OK) begin
							phase_n = PH_IGNORE;
						end else if (tok_n != '0) begin
							phase_n = PH_TOKEN;
						end else begin
							phase_n = PH_OPTION;
						end
					end
				end
				PH_TOKEN: begin
					role = ROLE_TOKEN;
					tok_n = tok_q - 4'd1;
					if (tok_n == '0) begin
						phase_n = PH_OPTION;
					end
				end
				PH_OPTION: begin
					if (b == PAYLOAD_MARK) begin
						role = ROLE_MARKER;
						phase_n = PH_PAYLOAD;
					end else if (seen_q >= limit) begin
						role = ROLE_IGNORED;
						phase_n = PH_IGNORE;
					end else begin
						role = ROLE_OPTHEAD;
						nib_n = b[3:0];
						len_n = '0;
						if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) begin
							err_n = STATUS_OPT_ERR;
							phase_n = PH_IGNORE;
						end else if (b[7:4] == NIB_EXT1) begin
							phase_n = PH_DEXT1;
						end else if (b[7:4] == NIB_EXT2) begin
							phase_n = PH_DEXT2A;
						end else begin
							num_n = num_q + {12'd0, b[7:4]};
							len_stage = 1'b1;
						end
					end
				end
				PH_DEXT1: begin
					role = ROLE_OPTHEAD;
					num_n = num_q + {8'd0, b} + EXT1_BIAS;
					len_stage = 1'b1;
				end
				PH_DEXT2A: begin
					role = ROLE_OPTHEAD;
					ext_n = b;
					phase_n = PH_DEXT2B;
				end
				PH_DEXT2B: begin
					role = ROLE_OPTHEAD;
					num_n = num_q + {ext_q, b} + EXT2_BIAS;
					len_stage = 1'b1;
				end
				PH_LEXT1: begin
					role = ROLE_OPTHEAD;
					set_len = 1'b1;
					len_val = {8'd0, b} + EXT1_BIAS;
				end
				PH_LEXT2A: begin
					role = ROLE_OPTHEAD;
					ext_n = b;
					phase_n = PH_LEXT2B;
				end
				PH_LEXT2B: begin
					role = ROLE_OPTHEAD;
					set_len = 1'b1;
					len_val = {ext_q, b} + EXT2_BIAS;
				end
				PH_VALUE: begin
					role = ROLE_OPTVALUE;
					rem_n = rem_q - 16'd1;
					if (rem_n == '0) begin
						finish = 1'b1;
					end
				end
				PH_PAYLOAD: role = ROLE_PAYLOAD;
				default: role = ROLE_IGNORED;
			endcase

			// delta known: now decode the length nibble
			if (len_stage) begin
				if (nib_n < NIB_EXT1) begin
					set_len = 1'b1;
					len_val = {12'd0, nib_n};
				end else if (nib_n == NIB_EXT1) begin
					phase_n = PH_LEXT1;
				end else begin
					phase_n = PH_LEXT2A;
				end
			end
			if (set_len) begin
				len_n = len_val;
				rem_n = len_val;
				if (len_val == '0) begin
					finish = 1'b1;
				end else begin
					phase_n = PH_VALUE;
				end
			end
			if (finish) begin
				if (seen_q != {OPT_W{1'b1}}) begin
					seen_n = seen_q + OPT_W'(1);
				end
				phase_n = PH_OPTION;
			end
		end
	end

	always_comb begin
		if (err_n != STATUS_OK) begin
			end_status = err_n;
		end else begin
			case (phase_n)
				PH_HEADER, PH_TOKEN: end_status = STATUS_DROPPED;
				PH_DEXT1, PH_DEXT2A, PH_DEXT2B, PH_LEXT1, PH_LEXT2A, PH_LEXT2B,
				PH_VALUE: end_status = STATUS_OPT_ERR;
				default: end_status = STATUS_OK;
			endcase
		end
	end

	always_comb begin
		result.byte_role = role;
		result.byte_value = b;
		result.message_type = hdr_n[29:28];
		result.token_length = hdr_n[27:24];
		result.message_code = hdr_n[23:16];
		result.message_id = hdr_n[15:0];
		if (role == ROLE_OPTHEAD || role == ROLE_OPTVALUE) begin
			result.option_number = num_n;
			result.option_length = len_n;
			result.option_index = seen_q;
		end else begin
			result.option_number = '0;
			result.option_length = '0;
			result.option_index = '0;
		end
		result.packet_end = item.last_byte;
		result.packet_status = item.last_byte ? end_status : STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q <= '0;
			hdr_q <= '0;
			tok_q <= '0;
			num_q <= '0;
			nib_q <= '0;
			ext_q <= '0;
			rem_q <= '0;
			seen_q <= '0;
			err_q <= STATUS_OK;
			len_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				// rearm for the next datagram
				phase_q <= PH_HEADER;
				cnt_q <= '0;
				hdr_q <= '0;
				tok_q <= '0;
				num_q <= '0;
				nib_q <= '0;
				ext_q <= '0;
				rem_q <= '0;
				seen_q <= '0;
				err_q <= STATUS_OK;
				len_q <= '0;
			end else begin
				phase_q <= phase_n;
				cnt_q <= cnt_n;
				hdr_q <= hdr_n;
				tok_q <= tok_n;
				num_q <= num_n;
				nib_q <= nib_n;
				ext_q <= ext_n;
				rem_q <= rem_n;
				seen_q <= seen_n;
				err_q <= err_n;
				len_q <= len_n;
			end
		end
	end

endmodule

[hw/rtl/coap_message_parser.sv]
`timescale 1ns / 1ps
// CoAP message parser: classifies the bytes of a received datagram.
// Input channel (in_valid / in_stall / in_data): one datagram byte per
// request, with last_byte set on the final byte. Output channel (out_valid /
// out_stall / out_data): exactly one result per byte, in order, carrying the
// byte's role, the header fields seen so far and, for option bytes, the
// running option number, value length and option index. The result of the
// last byte carries packet_end and the packet status, and the parser rearms.
// Config channel (cfg_valid / cfg_ready / cfg_data): option_limit, always
// ready; write it only while no datagram is in flight.
// Results are registered. Throughput: one byte per cycle while in_stall is
// low; each byte is decoded by a single pass of logic between the parser
// state registers and the result register.
// A result register plus one skid entry let one more byte in while the
// receiver stalls; in_stall rises only once the skid entry is full.
// Reset clears the parser to the start of a datagram, empties the output
// side and sets option_limit to 10.
module coap_message_parser #(
	parameter int MAX_DATAGRAM_BYTES = 1024,
	parameter int MAX_OPTIONS = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  coap_pkg::coap_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output coap_pkg::coap_out_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [coap_pkg::OPT_W-1:0] cfg_data
);
	import coap_pkg::*;
`include "coap_message_parser_assert.svh"

	logic [OPT_W-1:0] option_limit_q;
	logic             in_acc, out_free;
	coap_out_t        result;
	coap_out_t        out_q, skid_q;
	logic             out_vld_q, skid_vld_q;
	logic             opt_fields_ok;

	assign cfg_ready = 1'b1;
	assign in_stall = skid_vld_q;
	assign in_acc = in_valid && !skid_vld_q;
	assign out_free = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;
	assign out_data = out_q;

	// option fields are only meaningful on option bytes
	assign opt_fields_ok = out_q.byte_role == ROLE_OPTHEAD || out_q.byte_role == ROLE_OPTVALUE ||
		(out_q.option_number == 16'd0 && out_q.option_index == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_limit_q <= OPTION_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			option_limit_q <= cfg_data;
		end
	end

	coap_parse_core #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES),
		.MAX_OPTIONS(MAX_OPTIONS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_acc),
		.item(in_data),
		.option_limit(option_limit_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= skid_vld_q || in_acc;
			skid_vld_q <= 1'b0;
		end else if (in_acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : result;
		end else if (in_acc) begin
			skid_q <= result;
		end
	end

	`COAP_ASSERT(a_skid_needs_out, !skid_vld_q || out_vld_q)
	`COAP_ASSERT_NEXT(a_stalled_result_kept, out_vld_q && out_stall, out_vld_q)
	`COAP_ASSERT_NEXT(a_skid_kept, skid_vld_q && out_stall, skid_vld_q)
	`COAP_ASSERT(a_status_at_end, !out_vld_q || out_q.packet_end || out_q.packet_status == STATUS_OK)
	`COAP_ASSERT(a_opt_fields_zero, !out_vld_q || opt_fields_ok)

endmodule

[tb/coap_parse_sb_pkg.sv]
`timescale 1ns / 1ps
package coap_parse_sb_pkg;
	import coap_pkg::*;

	typedef enum logic [3:0] {
		P_HEADER, P_TOKEN, P_OPTION, P_DEXT1, P_DEXT2A, P_DEXT2B,
		P_LEXT1, P_LEXT2A, P_LEXT2B, P_VALUE, P_PAYLOAD, P_IGNORE
	} parse_phase_e;

	class coap_parse_scoreboard;
		int             buffer_bytes;
		coap_out_t      expected_results[$];
		int             mismatch_count;
		logic [3:0]     option_limit;

		parse_phase_e   parse_phase;
		int             nbytes;
		logic [31:0]    hdr;
		logic [3:0]     tok_left;
		logic [15:0]    opt_num;
		logic [7:0]     opt_head;
		logic [7:0]     ext_hi;
		logic [15:0]    val_left;
		logic [3:0]     opt_count;
		logic [1:0]     err;
		logic [15:0]    opt_len;

		function new(int buf_bytes);
			buffer_bytes = buf_bytes;
			mismatch_count = 0;
			option_limit = OPTION_LIMIT_RESET;
			clear_message();
		endfunction

		function void clear_message();
			parse_phase = P_HEADER;
			nbytes = 0;
			hdr = '0;
			tok_left = '0;
			opt_num = '0;
			opt_head = '0;
			ext_hi = '0;
			val_left = '0;
			opt_count = '0;
			err = STATUS_OK;
			opt_len = '0;
		endfunction

		function void close_option();
			if (opt_count != 4'd15)
				opt_count++;
			parse_phase = P_OPTION;
		endfunction

		function void take_length(logic [15:0] len);
			opt_len = len;
			val_left = len;
			if (len == 16'd0)
				close_option();
			else
				parse_phase = P_VALUE;
		endfunction

		function void decode_length();
			if (opt_head[3:0] < NIB_EXT1)
				take_length({12'd0, opt_head[3:0]});
			else if (opt_head[3:0] == NIB_EXT1)
				parse_phase = P_LEXT1;
			else
				parse_phase = P_LEXT2A;
		endfunction

		function logic [1:0] end_status();
			if (err != STATUS_OK)
				return err;
			case (parse_phase)
			P_HEADER, P_TOKEN: return STATUS_DROPPED;
			P_DEXT1, P_DEXT2A, P_DEXT2B, P_LEXT1, P_LEXT2A, P_LEXT2B, P_VALUE:
				return STATUS_OPT_ERR;
			default: return STATUS_OK;
			endcase
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Works out the result of one accepted request and queues it.
		function void note_byte(coap_in_t item);
			coap_out_t  e;
			logic [7:0] b;
			logic [3:0] idx;
			logic [3:0] dn;
			logic [2:0] role;
			b = item.data_byte;
			idx = opt_count;
			role = ROLE_IGNORED;
			if (nbytes < buffer_bytes) begin
				case (parse_phase)
				P_HEADER: begin
					role = ROLE_HEADER;
					hdr[(3 - nbytes) * 8 +: 8] = b;
					if (nbytes == 0 && (b[7:6] != COAP_VERSION || b[3:0] > TKL_MAX))
						err = STATUS_DROPPED;
					if (nbytes == 3) begin
						tok_left = hdr[27:24];
						if (err != STATUS_OK)
							parse_phase = P_IGNORE;
						else if (tok_left != 4'd0)
							parse_phase = P_TOKEN;
						else
							parse_phase = P_OPTION;
					end
				end
				P_TOKEN: begin
					role = ROLE_TOKEN;
					tok_left = tok_left - 4'd1;
					if (tok_left == 4'd0)
						parse_phase = P_OPTION;
				end
				P_OPTION: begin
					if (b == PAYLOAD_MARK) begin
						role = ROLE_MARKER;
						parse_phase = P_PAYLOAD;
					end else if (opt_count >= option_limit) begin
						role = ROLE_IGNORED;
						parse_phase = P_IGNORE;
					end else begin
						dn = b[7:4];
						role = ROLE_OPTHEAD;
						opt_head = b;
						opt_len = '0;
						if (dn == NIB_RSVD || b[3:0] == NIB_RSVD) begin
							err = STATUS_OPT_ERR;
							parse_phase = P_IGNORE;
						end else if (dn == NIB_EXT1) begin
							parse_phase = P_DEXT1;
						end else if (dn == NIB_EXT2) begin
							parse_phase = P_DEXT2A;
						end else begin
							opt_num = opt_num + {12'd0, dn};
							decode_length();
						end
					end
				end
				P_DEXT1: begin
					role = ROLE_OPTHEAD;
					opt_num = opt_num + {8'd0, b} + EXT1_BIAS;
					decode_length();
				end
				P_DEXT2A: begin
					role = ROLE_OPTHEAD;
					ext_hi = b;
					parse_phase = P_DEXT2B;
				end
				P_DEXT2B: begin
					role = ROLE_OPTHEAD;
					opt_num = opt_num + {ext_hi, b} + EXT2_BIAS;
					decode_length();
				end
				P_LEXT1: begin
					role = ROLE_OPTHEAD;
					take_length({8'd0, b} + EXT1_BIAS);
				end
				P_LEXT2A: begin
					role = ROLE_OPTHEAD;
					ext_hi = b;
					parse_phase = P_LEXT2B;
				end
				P_LEXT2B: begin
					role = ROLE_OPTHEAD;
					take_length({ext_hi, b} + EXT2_BIAS);
				end
				P_VALUE: begin
					role = ROLE_OPTVALUE;
					val_left = val_left - 16'd1;
					if (val_left == 16'd0)
						close_option();
				end
				P_PAYLOAD: role = ROLE_PAYLOAD;
				default: role = ROLE_IGNORED;
				endcase
				nbytes++;
			end

			e = '0;
			e.byte_role = role;
			e.byte_value = b;
			e.message_type = hdr[29:28];
			e.token_length = hdr[27:24];
			e.message_code = hdr[23:16];
			e.message_id = hdr[15:0];
			if (role == ROLE_OPTHEAD || role == ROLE_OPTVALUE) begin
				e.option_number = opt_num;
				e.option_length = opt_len;
				e.option_index = idx;
			end
			e.packet_end = item.last_byte;
			e.packet_status = item.last_byte ? end_status() : STATUS_OK;
			if (item.last_byte)
				clear_message();
			expected_results.push_back(e);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_result(coap_out_t got);
			coap_out_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, got);
				mismatch_count++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("byte_role", 16'(want.byte_role), 16'(got.byte_role));
			compare_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
			compare_field("message_type", 16'(want.message_type), 16'(got.message_type));
			compare_field("token_length", 16'(want.token_length), 16'(got.token_length));
			compare_field("message_code", 16'(want.message_code), 16'(got.message_code));
			compare_field("message_id", want.message_id, got.message_id);
			compare_field("option_number", want.option_number, got.option_number);
			compare_field("option_length", want.option_length, got.option_length);
			compare_field("option_index", 16'(want.option_index), 16'(got.option_index));
			compare_field("packet_end", 16'(want.packet_end), 16'(got.packet_end));
			compare_field("packet_status", 16'(want.packet_status), 16'(got.packet_status));
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import coap_pkg::*;
	import coap_parse_sb_pkg::*;

	localparam int BUF_BYTES = 1024;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_BYTES = 800;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	coap_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	coap_out_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [OPT_W-1:0]     cfg_data = '0;

	coap_parse_scoreboard sb = new(BUF_BYTES);
	int                   idle_pct = 14;
	bit                   hold_off_req = 1'b0;
	int                   bytes_sent = 0;
	logic [7:0]           msg[$];

	coap_message_parser #(
		.MAX_DATAGRAM_BYTES(BUF_BYTES),
		.MAX_OPTIONS(15)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if (cfg_valid && cfg_ready)
				sb.option_limit = cfg_data;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: last};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_message();
		foreach (msg[i])
			push_byte(msg[i], i == msg.size() - 1);
		bytes_sent += msg.size();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [OPT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// one option; cut is set when the value is too long and the message ends inside it
	task automatic build_option(output bit cut);
		int         dkind;
		int         lkind;
		int         len;
		logic [3:0] dn;
		logic [3:0] ln;
		logic [7:0] hi;
		logic [7:0] lo;
		cut = 1'b0;
		dkind = $urandom_range(9);
		lkind = $urandom_range(9);
		dn = dkind < 6 ? 4'($urandom_range(12)) : (dkind < 8 ? NIB_EXT1 : NIB_EXT2);
		ln = lkind < 7 ? 4'($urandom_range(12)) : (lkind < 9 ? NIB_EXT1 : NIB_EXT2);
		msg.push_back({dn, ln});
		if (dn == NIB_EXT1) begin
			msg.push_back(8'($urandom));
		end else if (dn == NIB_EXT2) begin
			msg.push_back(8'($urandom));
			msg.push_back(8'($urandom));
		end
		len = int'(ln);
		if (ln == NIB_EXT1) begin
			lo = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom);
			msg.push_back(lo);
			len = int'(lo) + 13;
		end else if (ln == NIB_EXT2) begin
			hi = 8'($urandom);
			lo = 8'($urandom);
			msg.push_back(hi);
			msg.push_back(lo);
			len = (int'({hi, lo}) + 269) % 65536;
		end
		if (len > 24) begin
			repeat ($urandom_range(6)) msg.push_back(8'($urandom));
			cut = 1'b1;
		end else begin
			repeat (len) msg.push_back(8'($urandom));
		end
	endtask

	task automatic build_message();
		int tkl;
		int nopt;
		bit cut;
		msg.delete();
		tkl = $urandom_range(8);
		msg.push_back({COAP_VERSION, 2'($urandom_range(3)), 4'(tkl)});
		repeat (3) msg.push_back(8'($urandom));
		repeat (tkl) msg.push_back(8'($urandom));
		// now and then enough options to run into the limit
		nopt = ($urandom_range(7) == 0) ? $urandom_range(17) : $urandom_range(5);
		cut = 1'b0;
		for (int i = 0; i < nopt && !cut; i++)
			build_option(cut);
		if (!cut && $urandom_range(9) < 6) begin
			msg.push_back(PAYLOAD_MARK);
			repeat ($urandom_range(8)) msg.push_back(8'($urandom));
		end
	endtask

	task automatic send_random_message();
		int kind;
		int keep;
		kind = $urandom_range(99);
		if (kind < 85) begin
			build_message();
			if (kind >= 70) begin
				if ($urandom_range(1)) begin
					keep = $urandom_range(msg.size() - 1, 1);
					msg = msg[0:keep-1];
				end else begin
					msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
				end
			end
		end else begin
			msg.delete();
			repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom));
		end
		send_message();
	endtask

	initial begin
		logic [OPT_W-1:0] limits[6];
		int               target;
		limits = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd10, 4'd7};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad version, trailing byte ignored
		msg = '{8'h00, 8'h01, 8'h12, 8'h34, 8'h55};
		send_message();
		// token length above 8
		msg = '{8'h79, 8'hFF, 8'hFF, 8'hFF};
		send_message();
		// ends inside the header
		msg = '{8'h40, 8'h00};
		send_message();
		// two-byte delta that wraps, then a reserved length nibble
		msg = '{8'h41, 8'h45, 8'h00, 8'h01, 8'hAA, 8'hE1, 8'hFF, 8'hFF, 8'h5A,
			8'h1F, 8'h00};
		send_message();
		drain();
		// no options allowed, marker as the last byte
		write_limit(4'd0);
		msg = '{8'h40, 8'h01, 8'h00, 8'h00, PAYLOAD_MARK};
		send_message();

		bytes_sent = 0;
		foreach (limits[p]) begin
			drain();
			write_limit(limits[p]);
			idle_pct = (p == 4) ? 0 : 14;
			if (p == 2)
				hold_off_req = 1'b1;
			target = RANDOM_BYTES * (p + 1) / 6;
			while (bytes_sent < target)
				send_random_message();
			if (p == 0) begin
				// runs past the buffer while inside a long option value
				msg = '{8'h40, 8'h01, 8'h12, 8'h34, 8'h0E, 8'h03, 8'hFC};
				while (msg.size() < BUF_BYTES + 6)
					msg.push_back(8'($urandom));
				send_message();
				// kept out of the random byte budget
				bytes_sent -= msg.size();
			end
		end
		drain();

		if (sb.mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/coap_pkg.sv
hw/rtl/coap_parse_core.sv
hw/rtl/coap_message_parser.sv
tb/coap_parse_sb_pkg.sv
tb/tb_top.sv
